// ===== design/assert_macros.svh =====
// assertion macros used by the top level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define VPIF_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define VPIF_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== design/vpif_pkg.sv =====
// types and constants of the voxel point insertion filter
package vpif_pkg;

  localparam int COORD_W       = 32;
  localparam int VOX_W         = 16;
  localparam int CNT_W         = 3;
  localparam int CTR_W         = 35;
  localparam int DIFF_W        = 36;
  localparam int AD_W          = 35;
  localparam int SQ_W          = 64;
  localparam int DIV_STEPS     = 32;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
  localparam int NEIGHBOURS_DEF = 5;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;

  localparam logic [VOX_W-1:0]  VOXEL_SIZE_RESET = 16'd512;
  localparam logic [ADDR_W-1:0] ADDR_VOXEL_SIZE  = 3'd0;

  localparam logic [1:0] VERDICT_DS     = 2'd0;
  localparam logic [1:0] VERDICT_DIRECT = 2'd1;
  localparam logic [1:0] VERDICT_DROP   = 2'd2;
  localparam logic [1:0] VERDICT_RSVD   = 2'd3;

  localparam logic MODE_QUERY = 1'b0;
  localparam logic MODE_NBR   = 1'b1;

  localparam logic [1:0] AXIS_LAST = 2'd2;

  typedef struct packed {
    logic                     mode;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [CNT_W-1:0]         neighbour_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               verdict;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV_INIT,
    ST_DIV,
    ST_CENTRE,
    ST_ABS,
    ST_SQ,
    ST_ACC,
    ST_EVAL
  } state_t;

  typedef struct packed {
    logic       load;
    logic       div_init;
    logic       div_step;
    logic       centre_wr;
    logic       acc_clr;
    logic       abs_step;
    logic       sq_step;
    logic       acc_step;
    logic       eval;
    logic [1:0] ax;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic pending;
    logic emit;
    logic out_busy;
  } status_t;

endpackage

// ===== design/vpif_ctrl.sv =====
// sequencer for division, distance and decision steps
module vpif_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  vpif_pkg::status_t st,
  output vpif_pkg::cmd_t    cmd
);

  vpif_pkg::state_t state_r, state_nxt;
  logic [1:0] ax_r, ax_nxt;
  logic [vpif_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vpif_pkg::ST_IDLE;
      ax_r    <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ax_r    <= ax_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ax_nxt    = ax_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.ax    = ax_r;
    in_ready  = 1'b0;
    case (state_r)
      vpif_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = vpif_pkg::ST_DECODE;
        end
      end
      vpif_pkg::ST_DECODE: begin
        ax_nxt = '0;
        if (st.mode == vpif_pkg::MODE_QUERY) begin
          cmd.acc_clr = 1'b1;
          state_nxt   = vpif_pkg::ST_DIV_INIT;
        end else if (st.pending) begin
          cmd.acc_clr = 1'b1;
          state_nxt   = vpif_pkg::ST_ABS;
        end else begin
          state_nxt = vpif_pkg::ST_IDLE;
        end
      end
      vpif_pkg::ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = vpif_pkg::ST_DIV;
      end
      vpif_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == vpif_pkg::DIV_CNT_W'(vpif_pkg::DIV_STEPS - 1)) begin
          state_nxt = vpif_pkg::ST_CENTRE;
        end
      end
      vpif_pkg::ST_CENTRE: begin
        cmd.centre_wr = 1'b1;
        if (ax_r == vpif_pkg::AXIS_LAST) begin
          ax_nxt    = '0;
          state_nxt = vpif_pkg::ST_ABS;
        end else begin
          ax_nxt    = ax_r + 1'b1;
          state_nxt = vpif_pkg::ST_DIV_INIT;
        end
      end
      vpif_pkg::ST_ABS: begin
        cmd.abs_step = 1'b1;
        state_nxt    = vpif_pkg::ST_SQ;
      end
      vpif_pkg::ST_SQ: begin
        cmd.sq_step = 1'b1;
        state_nxt   = vpif_pkg::ST_ACC;
      end
      vpif_pkg::ST_ACC: begin
        cmd.acc_step = 1'b1;
        if (ax_r == vpif_pkg::AXIS_LAST) begin
          ax_nxt    = '0;
          state_nxt = vpif_pkg::ST_EVAL;
        end else begin
          ax_nxt    = ax_r + 1'b1;
          state_nxt = vpif_pkg::ST_ABS;
        end
      end
      vpif_pkg::ST_EVAL: begin
        if (!(st.emit && st.out_busy)) begin
          cmd.eval  = 1'b1;
          state_nxt = vpif_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = vpif_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/vpif_dp.sv =====
// datapath: voxel remainder divider, squared distances, decision and result register
module vpif_dp #(
  parameter int NEIGHBOURS = vpif_pkg::NEIGHBOURS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  vpif_pkg::in_item_t                in_data,
  input  logic [vpif_pkg::VOX_W-1:0]        voxel_size,
  input  vpif_pkg::cmd_t                    cmd,
  output vpif_pkg::status_t                 st,
  output logic                              out_valid,
  input  logic                              out_ready,
  output vpif_pkg::out_item_t               out_data
);

  localparam int SEEN_W = $clog2(NEIGHBOURS + 1);
  localparam int CW = vpif_pkg::COORD_W;
  localparam int VW = vpif_pkg::VOX_W;

  logic [VW-1:0] v;
  logic                          mode_r;
  logic [vpif_pkg::CNT_W-1:0]    cnt_r;
  logic signed [CW-1:0]          qp_r [3];
  logic signed [CW-1:0]          pt_r [3];
  logic signed [vpif_pkg::CTR_W-1:0] centre_r [3];
  logic [CW-1:0]                 mag_r;
  logic [VW-1:0]                 rem_r;
  logic                          neg_r;
  logic [vpif_pkg::AD_W-1:0]     ad_r;
  logic [2:0]                    far_r;
  logic [vpif_pkg::SQ_W-1:0]     sq_r;
  logic [vpif_pkg::SQ_W-1:0]     acc_r;
  logic [vpif_pkg::SQ_W-1:0]     own_r;
  logic [SEEN_W-1:0]             seen_r;
  logic [SEEN_W-1:0]             exp_r;
  logic                          pending_r;
  logic                          out_valid_r;
  vpif_pkg::out_item_t           out_r;

  logic [VW:0]                   trial;
  logic [VW-1:0]                 r_fl;
  logic signed [vpif_pkg::CTR_W-1:0] centre_new;
  logic signed [vpif_pkg::DIFF_W-1:0] diff;
  logic [vpif_pkg::DIFF_W-1:0]   ad;
  logic [vpif_pkg::SQ_W:0]       sum;
  logic [SEEN_W-1:0]             exp_cap;
  logic [SEEN_W-1:0]             seen1;
  logic                          dec_emit;
  logic [1:0]                    dec_verdict;
  logic signed [CW-1:0]          x_sel;

  assign v     = (voxel_size == '0) ? VW'(1) : voxel_size;
  assign x_sel = qp_r[cmd.ax];
  assign trial = {rem_r, mag_r[CW-1]};
  assign r_fl  = (neg_r && rem_r != '0) ? (v - rem_r) : rem_r;
  assign centre_new = $signed({{2{x_sel[CW-1]}}, x_sel, 1'b0})
                    - $signed({18'b0, r_fl, 1'b0})
                    + $signed({19'b0, v});
  assign diff = $signed({{3{pt_r[cmd.ax][CW-1]}}, pt_r[cmd.ax], 1'b0})
              - $signed({centre_r[cmd.ax][vpif_pkg::CTR_W-1], centre_r[cmd.ax]});
  assign ad   = diff[vpif_pkg::DIFF_W-1] ? (-diff) : diff;
  assign sum  = {1'b0, acc_r} + {1'b0, sq_r};
  assign exp_cap = (int'(cnt_r) > NEIGHBOURS) ? SEEN_W'(NEIGHBOURS) : SEEN_W'(cnt_r);
  assign seen1   = seen_r + 1'b1;

  always_comb begin
    dec_emit    = 1'b0;
    dec_verdict = vpif_pkg::VERDICT_DS;
    if (mode_r == vpif_pkg::MODE_QUERY) begin
      dec_emit = (exp_cap == '0);
    end else if (seen_r == '0 && (&far_r)) begin
      dec_emit    = 1'b1;
      dec_verdict = vpif_pkg::VERDICT_DIRECT;
    end else if (seen_r == '0 && int'(exp_r) < NEIGHBOURS) begin
      dec_emit = 1'b1;
    end else if (acc_r < own_r) begin
      dec_emit    = 1'b1;
      dec_verdict = vpif_pkg::VERDICT_DROP;
    end else if (seen1 >= exp_r) begin
      dec_emit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_data.mode;
      cnt_r    <= in_data.neighbour_count;
      pt_r[0]  <= in_data.coord_x;
      pt_r[1]  <= in_data.coord_y;
      pt_r[2]  <= in_data.coord_z;
      if (in_data.mode == vpif_pkg::MODE_QUERY) begin
        qp_r[0] <= in_data.coord_x;
        qp_r[1] <= in_data.coord_y;
        qp_r[2] <= in_data.coord_z;
      end
    end
    if (cmd.div_init) begin
      neg_r <= x_sel[CW-1];
      mag_r <= x_sel[CW-1] ? (-x_sel) : x_sel;
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      mag_r <= {mag_r[CW-2:0], 1'b0};
      rem_r <= (trial >= {1'b0, v}) ? VW'(trial - {1'b0, v}) : trial[VW-1:0];
    end
    if (cmd.centre_wr) begin
      centre_r[cmd.ax] <= centre_new;
    end
    if (cmd.abs_step) begin
      ad_r           <= ad[vpif_pkg::AD_W-1:0];
      far_r[cmd.ax]  <= (ad > {20'b0, v});
    end
    if (cmd.sq_step) begin
      sq_r <= (ad_r[vpif_pkg::AD_W-1:CW] != '0) ? '1
            : vpif_pkg::SQ_W'(ad_r[CW-1:0]) * vpif_pkg::SQ_W'(ad_r[CW-1:0]);
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_step) begin
      acc_r <= sum[vpif_pkg::SQ_W] ? '1 : sum[vpif_pkg::SQ_W-1:0];
    end
    if (cmd.eval && dec_emit) begin
      out_r.verdict <= dec_verdict;
      out_r.point_x <= qp_r[0];
      out_r.point_y <= qp_r[1];
      out_r.point_z <= qp_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r       <= '0;
      seen_r      <= '0;
      exp_r       <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.eval && dec_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.eval) begin
        if (mode_r == vpif_pkg::MODE_QUERY) begin
          own_r     <= acc_r;
          exp_r     <= exp_cap;
          seen_r    <= '0;
          pending_r <= !dec_emit;
        end else begin
          if (!(seen_r == '0 && ((&far_r) || int'(exp_r) < NEIGHBOURS))) begin
            seen_r <= seen1;
          end
          if (dec_emit) begin
            pending_r <= 1'b0;
          end
        end
      end
    end
  end

  assign st.mode     = mode_r;
  assign st.pending  = pending_r;
  assign st.emit     = dec_emit;
  assign st.out_busy = out_valid_r && !out_ready;
  assign out_valid   = out_valid_r;
  assign out_data    = out_r;

endmodule

// ===== design/voxel_point_insertion_filter_unit.sv =====
// top level of the voxel point insertion filter
// usage:
//   in channel (in_valid/in_ready, in_data): a query point (mode 0) followed by
//   its nearest map neighbors (mode 1), one request each
//   out channel (out_valid/out_ready, out_data): at most one verdict per request,
//   carrying the query point
//   apb port: register 0 at byte address 0 is voxel_size, write only while idle
// request sequence (one request at a time, in_ready high only while idle):
//   query request: decode, then per axis the bit-serial remainder divider
//   and the centre write, then the per-axis square and accumulate loop, verdict
//   neighbor request: decode, the per-axis square and accumulate loop, verdict
//   stray neighbor (no open query): decode only, then back to idle
// reset: synchronous, clears the open query; voxel_size returns to 512
// stall: the verdict waits in an output register; the next request is accepted
//   meanwhile and only its own verdict step waits while out_ready is low
module voxel_point_insertion_filter_unit #(
  parameter int NEIGHBOURS = vpif_pkg::NEIGHBOURS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  vpif_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output vpif_pkg::out_item_t                 out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vpif_pkg::ADDR_W-1:0]         paddr,
  input  logic [vpif_pkg::DATA_W-1:0]         pwdata,
  output logic [vpif_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  `include "assert_macros.svh"

  logic [vpif_pkg::VOX_W-1:0] voxel_size_r;
  vpif_pkg::cmd_t    cmd;
  vpif_pkg::status_t st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voxel_size_r <= vpif_pkg::VOXEL_SIZE_RESET;
    end else if (psel && penable && pwrite && paddr == vpif_pkg::ADDR_VOXEL_SIZE) begin
      voxel_size_r <= pwdata[vpif_pkg::VOX_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == vpif_pkg::ADDR_VOXEL_SIZE)
                ? {{(vpif_pkg::DATA_W - vpif_pkg::VOX_W){1'b0}}, voxel_size_r} : '0;

  vpif_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  vpif_dp #(
    .NEIGHBOURS (NEIGHBOURS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .voxel_size (voxel_size_r),
    .cmd        (cmd),
    .st         (st),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  `VPIF_ASSERT_IMP(a_verdict_code, clk, rst_n, out_valid, out_data.verdict != vpif_pkg::VERDICT_RSVD)
  `VPIF_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
  `VPIF_ASSERT_NXT(a_no_instant_result, clk, rst_n, in_valid && in_ready, !$rose(out_valid))

endmodule

// ===== verif/voxel_point_insertion_filter_unit_tb.sv =====
// testbench of the voxel point insertion filter: directed table, random point sets, verdict check
`timescale 1ns / 100ps

module voxel_point_insertion_filter_unit_tb;

  localparam int NBR_MAX = vpif_pkg::NEIGHBOURS_DEF;

  typedef struct {
    vpif_pkg::in_item_t  req;
    bit                  typed;
    vpif_pkg::out_item_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  vpif_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  vpif_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [vpif_pkg::ADDR_W-1:0] paddr = '0;
  logic [vpif_pkg::DATA_W-1:0] pwdata = '0;
  logic [vpif_pkg::DATA_W-1:0] prdata;
  logic pready;

  voxel_point_insertion_filter_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // filter state mirrored by the verdict predictor
  logic [vpif_pkg::VOX_W-1:0] vox_size = vpif_pkg::VOXEL_SIZE_RESET;
  logic signed [vpif_pkg::COORD_W-1:0] q_pt [3];
  longint ctr [3];
  bit [63:0] own_dist;
  int seen_cnt, want_cnt;
  bit query_open;

  vpif_pkg::out_item_t verdict_q [$];
  row_t rows [$];
  int errors = 0;
  bit quiet = 1'b0;
  int stall_left = 0;

  function automatic bit [63:0] sq_sat(longint d);
    longint unsigned a;
    a = (d < 0) ? -d : d;
    if (a >= 64'h1_0000_0000) return '1;
    return a * a;
  endfunction

  function automatic bit [63:0] dist_to_ctr(longint p [3]);
    bit [64:0] s;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      s = s + sq_sat(p[k] - ctr[k]);
      if (s[64]) s = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
    end
    return s[63:0];
  endfunction

  function automatic vpif_pkg::out_item_t verdict_of(logic [1:0] v);
    vpif_pkg::out_item_t r;
    r.verdict = v;
    r.point_x = q_pt[0];
    r.point_y = q_pt[1];
    r.point_z = q_pt[2];
    return r;
  endfunction

  function automatic void add_row(vpif_pkg::in_item_t req, bit typed,
                                  vpif_pkg::out_item_t want);
    row_t rw;
    rw.req = req;
    rw.typed = typed;
    rw.want = want;
    rows.insert(rows.size(), rw);
  endfunction

  task automatic predict_verdict(vpif_pkg::in_item_t it, output bit has,
                                 output vpif_pkg::out_item_t r);
    longint v, x, q, d;
    longint p [3];
    bit far;
    has = 0;
    r = '0;
    v = (vox_size == 0) ? 1 : longint'(vox_size);
    p[0] = 2 * longint'(it.coord_x);
    p[1] = 2 * longint'(it.coord_y);
    p[2] = 2 * longint'(it.coord_z);
    if (it.mode == vpif_pkg::MODE_QUERY) begin
      q_pt[0] = it.coord_x;
      q_pt[1] = it.coord_y;
      q_pt[2] = it.coord_z;
      for (int k = 0; k < 3; k++) begin
        x = longint'(q_pt[k]);
        q = x / v;
        if (x % v != 0 && x < 0) q--;
        ctr[k] = 2 * q * v + v;
      end
      own_dist = dist_to_ctr(p);
      want_cnt = (it.neighbour_count > NBR_MAX) ? NBR_MAX : it.neighbour_count;
      seen_cnt = 0;
      query_open = 1;
      if (want_cnt == 0) begin
        has = 1; r = verdict_of(vpif_pkg::VERDICT_DS); query_open = 0;
      end
      return;
    end
    if (!query_open) return;
    if (seen_cnt == 0) begin
      far = 1;
      for (int k = 0; k < 3; k++) begin
        d = p[k] - ctr[k];
        if (d < 0) d = -d;
        if (d <= v) far = 0;
      end
      if (far) begin
        has = 1; r = verdict_of(vpif_pkg::VERDICT_DIRECT); query_open = 0; return;
      end
      if (want_cnt < NBR_MAX) begin
        has = 1; r = verdict_of(vpif_pkg::VERDICT_DS); query_open = 0; return;
      end
    end
    seen_cnt++;
    if (dist_to_ctr(p) < own_dist) begin
      has = 1; r = verdict_of(vpif_pkg::VERDICT_DROP); query_open = 0;
    end else if (seen_cnt >= want_cnt) begin
      has = 1; r = verdict_of(vpif_pkg::VERDICT_DS); query_open = 0;
    end
  endtask

  // caller stands at a falling edge
  task automatic send(vpif_pkg::in_item_t it, bit typed = 0,
                      vpif_pkg::out_item_t want = '0);
    bit has;
    vpif_pkg::out_item_t r;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_verdict(it, has, r);
    if (typed) begin
      if (!has) begin
        errors++;
        if (errors <= 10) $display("directed row: no verdict predicted for typed row");
      end
      r = want;
      has = 1;
    end
    if (has) verdict_q.insert(verdict_q.size(), r);
    @(negedge clk);
  endtask

  task automatic drain(int extra);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_voxel_size(logic [vpif_pkg::VOX_W-1:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= vpif_pkg::ADDR_VOXEL_SIZE; pwdata <= {16'h0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    vox_size = val;
  endtask

  function automatic vpif_pkg::in_item_t mk(logic m, int x, int y, int z, int cnt);
    vpif_pkg::in_item_t it;
    it.mode = m;
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    it.neighbour_count = cnt[vpif_pkg::CNT_W-1:0];
    return it;
  endfunction

  function automatic int near_off(int v);
    return $urandom_range(0, 2 * v) - v;
  endfunction

  function automatic int far_off(int v);
    int o;
    o = 2 * v + $urandom_range(0, v);
    return $urandom_range(0, 1) ? o : -o;
  endfunction

  task automatic random_sets(int n_items, bit pause_mid);
    int sent, v, cnt, k, bx, by, bz;
    bit paused;
    sent = 0;
    paused = 0;
    v = (vox_size == 0) ? 1 : int'(vox_size);
    while (sent < n_items) begin
      if (pause_mid && !paused && sent > n_items / 2) begin
        in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        @(negedge clk);
        paused = 1;
      end
      if ($urandom_range(0, 9) < 2) begin
        send(mk($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom_range(0, 7)));
        sent++;
        continue;
      end
      if ($urandom_range(0, 7) == 0) begin
        bx = $urandom; by = $urandom; bz = $urandom;
      end else begin
        bx = $urandom_range(0, 1 << 21) - (1 << 20);
        by = $urandom_range(0, 1 << 21) - (1 << 20);
        bz = $urandom_range(0, 1 << 21) - (1 << 20);
      end
      cnt = ($urandom_range(0, 2) != 0) ? NBR_MAX : $urandom_range(0, 7);
      send(mk(vpif_pkg::MODE_QUERY, bx, by, bz, cnt));
      sent++;
      k = (cnt > NBR_MAX) ? NBR_MAX : cnt;
      case ($urandom_range(0, 7))
        0: k = k + 1;
        1: if (k > 0) k = k - 1;
        default: ;
      endcase
      for (int i = 0; i < k; i++) begin
        if (i == 0 && $urandom_range(0, 5) == 0)
          send(mk(vpif_pkg::MODE_NBR, bx + far_off(v), by + far_off(v), bz + far_off(v),
                  $urandom));
        else
          send(mk(vpif_pkg::MODE_NBR, bx + near_off(v), by + near_off(v), bz + near_off(v),
                  $urandom));
        sent++;
      end
    end
  endtask

  always @(negedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    vpif_pkg::out_item_t w;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected verdict %0d point %0d %0d %0d",
                                   out_data.verdict, out_data.point_x,
                                   out_data.point_y, out_data.point_z);
      end else begin
        w = verdict_q.pop_front();
        if (out_data !== w) begin
          errors++;
          if (errors <= 10)
            $display("verdict mismatch: exp %0d (%0d %0d %0d) got %0d (%0d %0d %0d)",
                     w.verdict, w.point_x, w.point_y, w.point_z, out_data.verdict,
                     out_data.point_x, out_data.point_y, out_data.point_z);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    vpif_pkg::out_item_t e;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows at the reset voxel size
    e.verdict = vpif_pkg::VERDICT_DS; e.point_x = 0; e.point_y = 0; e.point_z = 0;
    add_row(mk(vpif_pkg::MODE_QUERY, 0, 0, 0, 0), 1'b1, e);
    e.point_x = 32'h7FFF_FFFF; e.point_y = 32'h7FFF_FFFF; e.point_z = 32'h7FFF_FFFF;
    add_row(mk(vpif_pkg::MODE_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0), 1'b1, e);
    e.point_x = 32'h8000_0000; e.point_y = 32'h8000_0000; e.point_z = 32'h8000_0000;
    add_row(mk(vpif_pkg::MODE_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0), 1'b1, e);
    // stray neighbor, nothing open
    add_row(mk(vpif_pkg::MODE_NBR, 5, 5, 5, 7), 1'b0, '0);
    // short set, far first neighbor
    add_row(mk(vpif_pkg::MODE_QUERY, 100, 100, 100, 2), 1'b0, '0);
    e.verdict = vpif_pkg::VERDICT_DIRECT; e.point_x = 100; e.point_y = 100; e.point_z = 100;
    add_row(mk(vpif_pkg::MODE_NBR, 100000, 100000, 100000, 0), 1'b1, e);
    add_row(mk(vpif_pkg::MODE_NBR, 100, 100, 100, 0), 1'b0, '0);
    // full set, neighbor on the center
    add_row(mk(vpif_pkg::MODE_QUERY, 100, 100, 100, 5), 1'b0, '0);
    e.verdict = vpif_pkg::VERDICT_DROP;
    add_row(mk(vpif_pkg::MODE_NBR, 256, 256, 256, 0), 1'b1, e);
    // abandoned query
    add_row(mk(vpif_pkg::MODE_QUERY, -700, 300, -1, 3), 1'b0, '0);
    add_row(mk(vpif_pkg::MODE_QUERY, -1, -512, 511, 0), 1'b0, '0);
    // count capped, equal distances keep the point
    add_row(mk(vpif_pkg::MODE_QUERY, 1000, -1000, 5, 7), 1'b0, '0);
    for (int i = 0; i < 5; i++) add_row(mk(vpif_pkg::MODE_NBR, 1000, -1000, 5, 0), 1'b0, '0);
    // saturating distances
    add_row(mk(vpif_pkg::MODE_QUERY, 32'h7FFF_FFFF, 0, 0, 5), 1'b0, '0);
    add_row(mk(vpif_pkg::MODE_NBR, 32'h7FFF_FFFF, 0, 0, 0), 1'b0, '0);
    add_row(mk(vpif_pkg::MODE_NBR, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0), 1'b0, '0);
    add_row(mk(vpif_pkg::MODE_NBR, 32'h7FFF_FFF0, 3, -3, 0), 1'b0, '0);
    add_row(mk(vpif_pkg::MODE_NBR, 32'h7FFF_FE00, 0, 0, 0), 1'b0, '0);
    foreach (rows[i]) send(rows[i].req, rows[i].typed, rows[i].want);

    random_sets(230, 1'b0);
    drain(200);
    write_voxel_size(16'd1);
    random_sets(230, 1'b1);
    drain(200);
    write_voxel_size(16'hFFFF);
    random_sets(230, 1'b0);
    drain(200);
    write_voxel_size(16'd0);
    random_sets(200, 1'b0);
    drain(200);
    write_voxel_size(16'd3);
    random_sets(230, 1'b0);
    drain(200);
    write_voxel_size(16'($urandom_range(2, 65534)));
    random_sets(230, 1'b0);
    drain(200);
    write_voxel_size(vpif_pkg::VOXEL_SIZE_RESET);
    quiet = 1'b1;
    random_sets(370, 1'b0);
    drain(200);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
